// File: hw/rtl/arpc_pkg.sv
// shared types and constants for the address-resolution table
package arpc_pkg;

  // command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // a slot stamped with this value never compares older; it is evicted only as the slot-0 fallback
  localparam logic [31:0] STAMP_NONE = 32'hFFFF_FFFF;

  // timeout after reset
  localparam logic [31:0] TIMEOUT_RST = 32'd60000;

  // one input word
  typedef struct packed {
    logic        cmd;
    logic [31:0] ip_addr;
    logic [47:0] hw_addr;
    logic [31:0] now_tick;
  } arpc_in_t;

  // one result word
  typedef struct packed {
    logic        hit;
    logic        expired;
    logic [47:0] found_mac;
    logic [3:0]  slot;
  } arpc_out_t;

  // contents of one table slot
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } arpc_entry_t;

  // outcome of comparing one slot against the search key
  typedef struct packed {
    logic ip_hit;
    logic older;
  } arpc_cmp_t;

endpackage

// File: hw/rtl/arpc_store.sv
// slot memory with registered read port and per-slot valid flags
module arpc_store import arpc_pkg::*; #(
  parameter int ENTRIES = 16,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_addr,
  output arpc_entry_t      rd_entry,
  output logic             rd_valid,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  arpc_entry_t      wr_entry,
  input  logic             vld_we,
  input  logic             vld_set
);

  // ip, mac and stamp; every slot is read on each scan, but its contents only count once written
  arpc_entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  arpc_entry_t rd_entry_r;
  logic rd_valid_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry_r <= mem[rd_addr];
  end

  // valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (vld_we) begin
        valid_r[wr_addr] <= vld_set;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_valid = rd_valid_r;

endmodule

// File: hw/rtl/arpc_cmp.sv
// compare unit shared by every step of the table scan
module arpc_cmp import arpc_pkg::*; (
  input  arpc_entry_t entry,
  input  logic        entry_valid,
  input  logic [31:0] key_ip,
  input  logic [31:0] best_stamp,
  output arpc_cmp_t   result
);

  // address match on a live slot, and stamp ordering for replacement
  always_comb begin
    result.ip_hit = entry_valid && (entry.ip == key_ip);
    result.older  = entry.stamp < best_stamp;
  end

endmodule

// File: hw/rtl/arp_cache_table.sv
// top level of the address-resolution table: sequencer, scan state and ports
//
// Input channel in_valid/in_ready/in_data carries one command word: add or
// refresh (ip_addr -> hw_addr, stamped with now_tick) or look up ip_addr.
// Every command gives exactly one result word on out_valid/out_ready/out_data.
// cfg_we/cfg_wdata set the stale-entry timeout, 60000 ticks after reset.
//
// A command walks all ENTRIES slots through one compare unit, one slot per
// cycle from the registered read port of the slot memory; then the sequencer
// writes back (S_ACT) and loads the output register (S_DONE), holding in
// S_DONE while the output register is full and not drained. out_valid rises
// in the same cycle in which in_ready returns; no further command is taken
// before the last one has reached the output register.
//
// Synchronous reset (rst_n low) clears all valid flags, the sequencer and
// the output valid flag; no clearing pass is needed. While the receiver holds
// out_ready low the result waits in the output register and the block can
// accept and work on one further command, which then waits until the
// output register is free.
module arp_cache_table import arpc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  arpc_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output arpc_out_t   out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ACT  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  arpc_in_t         item_r, item_nxt;
  logic             match_r, match_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic [31:0]      match_stamp_r, match_stamp_nxt;
  logic [47:0]      match_mac_r, match_mac_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [31:0]      best_stamp_r, best_stamp_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  arpc_out_t        res_r, res_nxt;
  arpc_out_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      timeout_r;

  logic             in_fire;
  logic [IDX_W-1:0] rd_addr;
  arpc_entry_t      rd_entry;
  logic             rd_valid;
  logic             wr_en;
  logic             vld_we;
  logic             vld_set;
  logic [IDX_W-1:0] wr_addr;
  arpc_entry_t      wr_entry;
  arpc_cmp_t        cmp;
  logic [31:0]      age;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign rd_addr   = issue_r[IDX_W-1:0];
  assign age       = item_r.now_tick - match_stamp_r;

  // slot storage
  arpc_store #(.ENTRIES(ENTRIES)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .vld_we   (vld_we),
    .vld_set  (vld_set)
  );

  // per-slot compare
  arpc_cmp u_cmp (
    .entry       (rd_entry),
    .entry_valid (rd_valid),
    .key_ip      (item_r.ip_addr),
    .best_stamp  (best_stamp_r),
    .result      (cmp)
  );

  // sequencer, scan accumulators and write-back
  always_comb begin
    state_nxt       = state_r;
    issue_nxt       = issue_r;
    rd_pend_nxt     = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    item_nxt        = item_r;
    match_nxt       = match_r;
    match_idx_nxt   = match_idx_r;
    match_stamp_nxt = match_stamp_r;
    match_mac_nxt   = match_mac_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    best_stamp_nxt  = best_stamp_r;
    best_idx_nxt    = best_idx_r;
    res_nxt         = res_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r;
    wr_en           = 1'b0;
    vld_we          = 1'b0;
    vld_set         = 1'b0;
    wr_addr         = match_idx_r;
    wr_entry.ip     = item_r.ip_addr;
    wr_entry.mac    = item_r.hw_addr;
    wr_entry.stamp  = item_r.now_tick;

    // output register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          item_nxt       = in_data;
          issue_nxt      = '0;
          match_nxt      = 1'b0;
          free_nxt       = 1'b0;
          best_stamp_nxt = STAMP_NONE;
          best_idx_nxt   = '0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one read per cycle
        if (issue_r < CNT_W'(ENTRIES)) begin
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = issue_r[IDX_W-1:0];
          issue_nxt   = issue_r + CNT_W'(1);
        end
        // fold in the slot read last cycle
        if (rd_pend_r) begin
          if (!match_r && cmp.ip_hit) begin
            match_nxt       = 1'b1;
            match_idx_nxt   = rd_idx_r;
            match_stamp_nxt = rd_entry.stamp;
            match_mac_nxt   = rd_entry.mac;
          end
          if (!free_r && !rd_valid) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
          if (cmp.older) begin
            best_stamp_nxt = rd_entry.stamp;
            best_idx_nxt   = rd_idx_r;
          end
          if (rd_idx_r == LAST_IDX) begin
            state_nxt = S_ACT;
          end
        end
      end
      S_ACT: begin
        res_nxt = '0;
        if (item_r.cmd == CMD_ADD) begin
          // refresh, else lowest free slot, else oldest stamp
          priority if (match_r) begin
            wr_addr = match_idx_r;
          end else if (free_r) begin
            wr_addr = free_idx_r;
          end else begin
            wr_addr = best_idx_r;
          end
          wr_en        = 1'b1;
          vld_we       = 1'b1;
          vld_set      = 1'b1;
          res_nxt.hit  = match_r;
          res_nxt.slot = 4'(wr_addr);
        end else if (match_r) begin
          if (age < timeout_r) begin
            res_nxt.hit       = 1'b1;
            res_nxt.found_mac = match_mac_r;
            res_nxt.slot      = 4'(match_idx_r);
          end else begin
            // stale entry is dropped
            vld_we          = 1'b1;
            vld_set         = 1'b0;
            res_nxt.expired = 1'b1;
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  // scan and payload registers
  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    item_r        <= item_nxt;
    match_r       <= match_nxt;
    match_idx_r   <= match_idx_nxt;
    match_stamp_r <= match_stamp_nxt;
    match_mac_r   <= match_mac_nxt;
    free_r        <= free_nxt;
    free_idx_r    <= free_idx_nxt;
    best_stamp_r  <= best_stamp_nxt;
    best_idx_r    <= best_idx_nxt;
    res_r         <= res_nxt;
    out_r         <= out_nxt;
  end

  // in_ready drops once a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while a command was in flight");

  // the table is only modified in the write-back step
  a_write_in_act: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en || vld_we) |-> (state_r == S_ACT))
    else $error("table written outside write-back");

  // a result never reports both a hit and an expiry
  a_hit_xor_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.expired))
    else $error("hit and expired both set");

  // a miss carries no mac
  a_miss_no_mac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> (out_data.found_mac == 48'd0))
    else $error("mac reported on a miss");

endmodule

// File: tb/tb_arp_cache_table.sv
// testbench for the address-resolution table: random traffic against a predictor
`timescale 1ns / 1ps

module tb_arp_cache_table;
  import arpc_pkg::*;

  localparam int ENTRIES      = 16;
  localparam int POOL_SIZE    = 20;
  localparam int LIMIT_CYCLES = 600000;
  localparam int LONG_HOLD    = 400;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  arpc_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  arpc_out_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;

  arp_cache_table #(.ENTRIES(ENTRIES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // words waiting to be sent and replies the table should give
  arpc_in_t  cmd_q[$];
  arpc_out_t reply_q[$];

  // shadow copy of the table
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_ip    [ENTRIES];
  logic [47:0] tbl_mac   [ENTRIES];
  logic [31:0] tbl_stamp [ENTRIES];
  logic [31:0] cur_timeout = TIMEOUT_RST;

  logic [31:0] ip_pool [POOL_SIZE];
  logic [31:0] run_tick;

  int errors        = 0;
  int words_sent    = 0;
  int replies_seen  = 0;
  int hits_seen     = 0;
  int stale_seen    = 0;
  int cfg_writes    = 0;
  int cycle_cnt     = 0;
  int burst_left    = 1;
  int gap_left      = 0;
  int hold_left     = 0;
  int held_once     = 0;
  int rx_mode       = 0;
  int rx_mode_left  = 0;
  int rx_tick       = 0;

  initial begin
    for (int k = 0; k < ENTRIES; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_ip[k]    = '0;
      tbl_mac[k]   = '0;
      tbl_stamp[k] = '0;
    end
  end

  // resolve one command against the shadow table and update it
  function automatic arpc_out_t predict_reply(arpc_in_t w);
    arpc_out_t   r;
    int          m;
    logic [31:0] least;
    logic [31:0] age;
    r = '0;
    m = -1;
    for (int k = ENTRIES - 1; k >= 0; k--)
      if (tbl_valid[k] && tbl_ip[k] == w.ip_addr) m = k;
    if (w.cmd == CMD_ADD) begin
      if (m >= 0) begin
        r.hit = 1'b1;
      end else begin
        for (int k = ENTRIES - 1; k >= 0; k--)
          if (!tbl_valid[k]) m = k;
        // full table: evict the oldest stamp, or slot 0 if every stamp is at the sentinel
        if (m < 0) begin
          m = 0;
          least = STAMP_NONE;
          for (int k = 0; k < ENTRIES; k++)
            if (tbl_stamp[k] < least) begin
              least = tbl_stamp[k];
              m = k;
            end
        end
        tbl_ip[m]    = w.ip_addr;
        tbl_valid[m] = 1'b1;
      end
      tbl_mac[m]   = w.hw_addr;
      tbl_stamp[m] = w.now_tick;
      r.slot       = 4'(m);
    end else if (m >= 0) begin
      age = w.now_tick - tbl_stamp[m];
      if (age < cur_timeout) begin
        r.hit       = 1'b1;
        r.found_mac = tbl_mac[m];
        r.slot      = 4'(m);
      end else begin
        tbl_valid[m] = 1'b0;
        r.expired    = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), $urandom};
  endfunction

  task automatic queue_word(input logic c, input logic [31:0] ip, input logic [47:0] mac,
                            input logic [31:0] now);
    arpc_in_t w;
    w.cmd      = c;
    w.ip_addr  = ip;
    w.hw_addr  = mac;
    w.now_tick = now;
    cmd_q.push_back(w);
  endtask

  // random traffic: pool runs, timeout boundary pairs, noise, stamp saturation
  task automatic queue_traffic(input int count, input logic [31:0] tmo);
    int          n;
    int          sel;
    int          len;
    logic [31:0] ip;
    logic [31:0] t;
    logic [31:0] step;
    logic [31:0] base;
    n = 0;
    base = $urandom;
    for (int k = 0; k < POOL_SIZE; k++)
      ip_pool[k] = (k < 16) ? base + k : $urandom;
    run_tick = $urandom;
    while (n < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        // mixed adds and lookups on a small address pool
        len = $urandom_range(4, 24);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 3))
            0: step = 0;
            1: step = $urandom_range(0, 3);
            2: step = $urandom_range(0, tmo / 2);
            default: step = tmo - 2 + $urandom_range(0, 3);
          endcase
          run_tick = run_tick + step;
          queue_word($urandom_range(0, 1) ? CMD_LOOKUP : CMD_ADD,
                     ip_pool[$urandom_range(0, POOL_SIZE - 1)], rand_mac(), run_tick);
        end
        n += len;
      end else if (sel < 80) begin
        // add then look up at the stale boundary or at the same tick
        ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        t  = $urandom;
        queue_word(CMD_ADD, ip, rand_mac(), t);
        case ($urandom_range(0, 2))
          0: queue_word(CMD_LOOKUP, ip, rand_mac(), t + tmo - 1);
          1: queue_word(CMD_LOOKUP, ip, rand_mac(), t + tmo);
          default: queue_word(CMD_LOOKUP, ip, rand_mac(), t);
        endcase
        n += 2;
      end else if (sel < 95) begin
        // unrelated words with every field random
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          queue_word($urandom_range(0, 1) ? CMD_LOOKUP : CMD_ADD, $urandom, rand_mac(), $urandom);
        n += len;
      end else begin
        // all stamps at the sentinel, so the next add falls back to slot 0
        for (int i = 0; i < ENTRIES + 1; i++)
          queue_word(CMD_ADD, $urandom, rand_mac(), STAMP_NONE);
        queue_word(CMD_LOOKUP, ip_pool[$urandom_range(0, POOL_SIZE - 1)], rand_mac(), $urandom);
        n += ENTRIES + 2;
      end
    end
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_valid || reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] v);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    cur_timeout = v;
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender: bursts of words with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        reply_q.push_back(predict_reply(in_data));
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          in_data  <= cmd_q.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each reply, stall on a changing pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected reply, expected none, got %h", $time, out_data);
        end else begin
          arpc_out_t exp_r;
          exp_r = reply_q.pop_front();
          if (out_data.hit !== exp_r.hit) begin
            errors++;
            $display("%0t: hit mismatch, expected %0b, got %0b", $time, exp_r.hit, out_data.hit);
          end
          if (out_data.expired !== exp_r.expired) begin
            errors++;
            $display("%0t: expired mismatch, expected %0b, got %0b", $time, exp_r.expired,
                     out_data.expired);
          end
          if (out_data.found_mac !== exp_r.found_mac) begin
            errors++;
            $display("%0t: found_mac mismatch, expected %h, got %h", $time, exp_r.found_mac,
                     out_data.found_mac);
          end
          if (out_data.slot !== exp_r.slot) begin
            errors++;
            $display("%0t: slot mismatch, expected %0d, got %0d", $time, exp_r.slot,
                     out_data.slot);
          end
          if (exp_r.hit) hits_seen++;
          if (exp_r.expired) stale_seen++;
        end
        replies_seen++;
      end
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (held_once == 0 && replies_seen >= 60) begin
        // long hold-off so the table backs up into its input
        held_once = 1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        if (rx_mode_left <= 0) begin
          rx_mode      = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(32, 256);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (rx_tick % 4 == 0);
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, refresh, stale boundary, fill and evict
    queue_word(CMD_LOOKUP, 32'h0, 48'h0, 32'h0);
    queue_word(CMD_ADD, 32'h0, 48'h0, 32'h0);
    queue_word(CMD_ADD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_word(CMD_ADD, 32'h0, 48'hFFFF_FFFF_FFFF, 32'd10);
    queue_word(CMD_LOOKUP, 32'h0, 48'h0, 32'd10 + TIMEOUT_RST - 1);
    queue_word(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0, TIMEOUT_RST - 2);
    queue_word(CMD_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF, 32'd10 + TIMEOUT_RST);
    queue_word(CMD_LOOKUP, 32'h0, 48'h0, 32'd10 + TIMEOUT_RST);
    queue_word(CMD_ADD, 32'h0A00_0000, rand_mac(), 32'd300);
    for (int k = 1; k < ENTRIES - 1; k++)
      queue_word(CMD_ADD, 32'h0A00_0000 + k, rand_mac(), 32'd200);
    queue_word(CMD_ADD, 32'hC0A8_0101, rand_mac(), 32'd400);
    queue_word(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0, 32'd5);

    // random phases over a range of timeouts
    write_timeout(32'd1000);
    queue_traffic(225, 32'd1000);
    write_timeout(32'd1);
    queue_traffic(225, 32'd1);
    write_timeout(32'hFFFF_FFFF);
    queue_traffic(225, 32'hFFFF_FFFF);
    begin
      logic [31:0] mid;
      mid = $urandom_range(2, 1000000);
      write_timeout(mid);
      queue_traffic(225, mid);
    end
    write_timeout(TIMEOUT_RST);
    queue_traffic(225, TIMEOUT_RST);

    wait_idle();
    repeat (ENTRIES + 8) @(posedge clk);
    $display("sent %0d words, checked %0d replies (%0d hits, %0d stale)",
             words_sent, replies_seen, hits_seen, stale_seen);
    $display("%0d timeout settings written, %0d mismatches", cfg_writes, errors);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_store.sv
hw/rtl/arpc_cmp.sv
hw/rtl/arp_cache_table.sv
tb/tb_arp_cache_table.sv
